[hw/rtl/rai_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_pkg
// shared types, constants and helpers of the ray versus box slab test
// ----------------------------------------------------------------------------
package rai_pkg;

    // quotient bits per plane distance, bits 32 down to 0
    localparam int DIV_STEPS = 33;

    // |dir| below this raw value counts as parallel to the axis
    localparam logic [31:0] NEAR_ZERO = 32'd1074;

    localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    // result codes
    localparam logic [1:0] OC_HIT      = 2'd0;
    localparam logic [1:0] OC_PARALLEL = 2'd1;
    localparam logic [1:0] OC_EMPTY    = 2'd2;
    localparam logic [1:0] OC_RANGE    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_RAY_LEN  = 3'd6;

    typedef struct packed {
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
    } t_box;

    // one division in flight
    typedef struct packed {
        logic [31:0] r;     // partial remainder
        logic [2:0]  fd;    // numerator bits still to shift in
        logic [32:0] q;     // quotient magnitude so far
        logic        neg;   // sign of the quotient
        logic        ovf;   // quotient >= 2^33 or |offset| >= 2^32
    } t_lane;

    // lanes 0..2 use the lower corner, 3..5 the upper corner
    typedef struct packed {
        t_lane [5:0] lane;
        logic  [2:0] par;   // axis parallel
        logic  [2:0] prej;  // origin outside slab
    } t_div;

    typedef struct packed {
        logic              done;
        logic [1:0]        code;
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
    } t_fold;

    typedef struct packed {
        logic              hit;
        logic signed [31:0] hdist;
        logic [1:0]        code;
    } t_res;

    // fold one axis into the running interval
    function automatic t_fold fold_axis(input t_fold s, input logic par, input logic prej,
                                        input logic signed [31:0] t1,
                                        input logic signed [31:0] t2);
        t_fold n;
        n = s;
        if (!s.done) begin
            if (par) begin
                if (prej) begin
                    n.done = 1'b1;
                    n.code = OC_PARALLEL;
                end
            end else begin
                if (t1 > s.t_near) n.t_near = t1;
                if (t2 < s.t_far)  n.t_far  = t2;
                if (n.t_near > n.t_far) begin
                    n.done = 1'b1;
                    n.code = OC_EMPTY;
                end
            end
        end
        return n;
    endfunction

endpackage

[hw/rtl/rai_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai stream interfaces
// box request channel and result channel, valid/ready
// ----------------------------------------------------------------------------
interface rai_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rai_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] hit_distance;
    logic [1:0]         outcome;

    modport source (output valid, hit, hit_distance, outcome, input ready);
    modport sink   (input valid, hit, hit_distance, outcome, output ready);
endinterface

[hw/rtl/rai_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_front
// plane offsets, signs, overflow test and parallel-slab check per box
// ----------------------------------------------------------------------------
module rai_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  rai_pkg::t_box        i_box,
    input  logic [2:0][31:0]     i_org,
    input  logic [2:0][31:0]     i_dabs,
    input  logic [2:0]           i_dneg,
    input  logic [2:0]           i_par,
    input  logic                 i_nxt_rdy,
    output logic                 o_vld,
    output rai_pkg::t_div        o_div
);
    import rai_pkg::*;

    logic r_vld;
    t_div r_div;
    t_div n_div;

    function automatic t_lane lane_init(input logic [31:0] bnd, input logic [31:0] org,
                                        input logic [31:0] dabs, input logic dneg);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        t_lane              l;
        diff  = $signed({bnd[31], bnd}) - $signed({org[31], org});
        mag   = diff[32] ? 33'(-diff) : 33'(diff);
        l.r   = {3'b000, mag[31:3]};
        l.fd  = mag[2:0];
        l.q   = '0;
        l.neg = diff[32] ^ dneg;
        l.ovf = ({3'b000, mag[31:3]} >= dabs) || mag[32];
        return l;
    endfunction

    always_comb begin
        n_div = '0;
        for (int a = 0; a < 3; a++) begin
            n_div.lane[a]   = lane_init(i_box.lo[a], i_org[a], i_dabs[a], i_dneg[a]);
            n_div.lane[a+3] = lane_init(i_box.hi[a], i_org[a], i_dabs[a], i_dneg[a]);
            n_div.par[a]    = i_par[a];
            n_div.prej[a]   = ($signed(i_org[a]) < $signed(i_box.lo[a])) ||
                              ($signed(i_org[a]) > $signed(i_box.hi[a]));
        end
    end

    assign o_rdy = !r_vld || i_nxt_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

[hw/rtl/rai_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_cell
// one restoring-division step for all six plane distances
// ----------------------------------------------------------------------------
module rai_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  rai_pkg::t_div        i_div,
    input  logic [2:0][31:0]     i_dabs,
    input  logic                 i_nxt_rdy,
    output logic                 o_vld,
    output rai_pkg::t_div        o_div
);
    import rai_pkg::*;

    logic r_vld;
    t_div r_div;
    t_div n_div;

    function automatic t_lane step_lane(input t_lane l, input logic [31:0] d);
        logic [32:0] sh;
        logic [32:0] dif;
        logic        ge;
        t_lane       n;
        sh    = {l.r, l.fd[2]};
        dif   = sh - {1'b0, d};
        ge    = sh >= {1'b0, d};
        n.r   = ge ? dif[31:0] : sh[31:0];
        n.fd  = {l.fd[1:0], 1'b0};
        n.q   = {l.q[31:0], ge};
        n.neg = l.neg;
        n.ovf = l.ovf;
        return n;
    endfunction

    always_comb begin
        n_div = i_div;
        for (int a = 0; a < 3; a++) begin
            n_div.lane[a]   = step_lane(i_div.lane[a], i_dabs[a]);
            n_div.lane[a+3] = step_lane(i_div.lane[a+3], i_dabs[a]);
        end
    end

    assign o_rdy = !r_vld || i_nxt_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

[hw/rtl/rai_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_back
// saturation, interval fold and range check, ending in the result register
// ----------------------------------------------------------------------------
module rai_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  rai_pkg::t_div        i_div,
    input  logic [30:0]          i_ray_len,
    input  logic                 i_nxt_rdy,
    output logic                 o_vld,
    output rai_pkg::t_res        o_res
);
    import rai_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] t1;
        logic [2:0][31:0] t2;
        logic [2:0]       par;
        logic [2:0]       prej;
    } t_ord;

    typedef struct packed {
        t_fold       fold;
        logic [31:0] t1;
        logic [31:0] t2;
        logic        par;
        logic        prej;
    } t_mid;

    logic  r_v1, r_v2, r_v3;
    logic  w_rdy1, w_rdy2, w_rdy3;
    t_ord  r_ord, n_ord;
    t_mid  r_mid, n_mid;
    t_res  r_res, n_res;

    function automatic logic signed [31:0] sat_q(input t_lane l);
        if (!l.neg) begin
            return (l.ovf || l.q[32:31] != 2'b00) ? T_MAX : $signed(l.q[31:0]);
        end
        return (l.ovf || l.q > 33'h0_8000_0000) ? T_MIN : $signed(-l.q[31:0]);
    endfunction

    // stage 1: saturate and order each pair
    always_comb begin
        logic signed [31:0] ta, tb;
        n_ord = '0;
        for (int a = 0; a < 3; a++) begin
            ta = sat_q(i_div.lane[a]);
            tb = sat_q(i_div.lane[a+3]);
            n_ord.t1[a] = (ta > tb) ? tb : ta;
            n_ord.t2[a] = (ta > tb) ? ta : tb;
        end
        n_ord.par  = i_div.par;
        n_ord.prej = i_div.prej;
    end

    // stage 2: fold x then y
    always_comb begin
        t_fold s;
        s.done   = 1'b0;
        s.code   = OC_HIT;
        s.t_near = T_MIN;
        s.t_far  = T_MAX;
        s = fold_axis(s, r_ord.par[0], r_ord.prej[0], r_ord.t1[0], r_ord.t2[0]);
        s = fold_axis(s, r_ord.par[1], r_ord.prej[1], r_ord.t1[1], r_ord.t2[1]);
        n_mid.fold = s;
        n_mid.t1   = r_ord.t1[2];
        n_mid.t2   = r_ord.t2[2];
        n_mid.par  = r_ord.par[2];
        n_mid.prej = r_ord.prej[2];
    end

    // stage 3: fold z, pick the distance, range check
    always_comb begin
        t_fold              s;
        logic signed [31:0] d;
        s = fold_axis(r_mid.fold, r_mid.par, r_mid.prej, r_mid.t1, r_mid.t2);
        d = (s.t_near >= 0) ? s.t_near : s.t_far;
        if (s.done) begin
            n_res.hit   = 1'b0;
            n_res.hdist = '0;
            n_res.code  = s.code;
        end else if (d >= 0 && d <= $signed({1'b0, i_ray_len})) begin
            n_res.hit   = 1'b1;
            n_res.hdist = d;
            n_res.code  = OC_HIT;
        end else begin
            n_res.hit   = 1'b0;
            n_res.hdist = d;
            n_res.code  = OC_RANGE;
        end
    end

    assign w_rdy3 = !r_v3 || i_nxt_rdy;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_rdy  = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_vld;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_vld) r_ord <= n_ord;
        if (w_rdy2 && r_v1)  r_mid <= n_mid;
        if (w_rdy3 && r_v2)  r_res <= n_res;
    end

    assign o_vld = r_v3;
    assign o_res = r_res;

endmodule

[hw/rtl/ray_aabb_slab_intersect_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersect_top
// slab-method ray versus axis-aligned box test, fixed point
// ----------------------------------------------------------------------------
// usage
//   the ray (origin, direction, length) sits in configuration registers,
//   written through i_cfg_we / i_cfg_idx / i_cfg_wdata while the block is idle
//   box requests enter on i_box (valid/ready), one result per box leaves on
//   o_res in request order
// throughput and datapath
//   one box per cycle sustained while o_res is ready; the front register
//   loads on the accepting edge, then a chain of 33 division cells (one
//   quotient bit per cell, six plane distances side by side) and three
//   back stages, the last being the result register, carry it to o_res
// stall behavior
//   every stage holds its own valid bit; a stage takes new data when empty
//   or when its successor moves, so bubbles close up while o_res stalls and
//   up to 37 requests can be in flight before i_box.ready drops
// reset
//   i_rst_n low clears all valid bits and loads the default ray: origin 0,
//   direction +z, length 1000.0
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersect_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    rai_box_if.sink     i_box,
    rai_res_if.source   o_res
);
    import rai_pkg::*;

    // ray registers
    logic [2:0][31:0] r_org;
    logic [2:0][31:0] r_dir;
    logic [30:0]      r_ray_len;

    // per-axis divisor magnitude, sign and parallel flag
    logic [2:0][31:0] w_dabs;
    logic [2:0]       w_dneg;
    logic [2:0]       w_par;

    // chain links: index 0 is the front register, DIV_STEPS the last cell
    logic w_vld [0:DIV_STEPS];
    logic w_rdy [0:DIV_STEPS];
    t_div w_div [0:DIV_STEPS];

    t_box w_box;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org     <= '0;
            r_dir     <= {32'sh4000_0000, 32'd0, 32'd0};
            r_ray_len <= 31'd65536000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_org[0]  <= i_cfg_wdata;
                REG_ORIGIN_Y: r_org[1]  <= i_cfg_wdata;
                REG_ORIGIN_Z: r_org[2]  <= i_cfg_wdata;
                REG_DIR_X:    r_dir[0]  <= i_cfg_wdata;
                REG_DIR_Y:    r_dir[1]  <= i_cfg_wdata;
                REG_DIR_Z:    r_dir[2]  <= i_cfg_wdata;
                REG_RAY_LEN:  r_ray_len <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // the user keeps the ray steady while requests are in flight; not enforced
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dneg[a] = r_dir[a][31];
            w_dabs[a] = r_dir[a][31] ? 32'(-r_dir[a]) : r_dir[a];
            w_par[a]  = w_dabs[a] < NEAR_ZERO;
        end
    end

    assign w_box.lo = {i_box.box_min_z, i_box.box_min_y, i_box.box_min_x};
    assign w_box.hi = {i_box.box_max_z, i_box.box_max_y, i_box.box_max_x};

    rai_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_box.valid),
        .o_rdy     (i_box.ready),
        .i_box     (w_box),
        .i_org     (r_org),
        .i_dabs    (w_dabs),
        .i_dneg    (w_dneg),
        .i_par     (w_par),
        .i_nxt_rdy (w_rdy[0]),
        .o_vld     (w_vld[0]),
        .o_div     (w_div[0])
    );

    // division chain, one quotient bit per cell, msb first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        rai_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (w_vld[k]),
            .o_rdy     (w_rdy[k]),
            .i_div     (w_div[k]),
            .i_dabs    (w_dabs),
            .i_nxt_rdy (w_rdy[k+1]),
            .o_vld     (w_vld[k+1]),
            .o_div     (w_div[k+1])
        );
    end

    rai_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_vld[DIV_STEPS]),
        .o_rdy     (w_rdy[DIV_STEPS]),
        .i_div     (w_div[DIV_STEPS]),
        .i_ray_len (r_ray_len),
        .i_nxt_rdy (o_res.ready),
        .o_vld     (o_res.valid),
        .o_res     (w_res)
    );

    assign o_res.hit          = w_res.hit;
    assign o_res.hit_distance = w_res.hdist;
    assign o_res.outcome      = w_res.code;

    // hit flag and result code agree
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.hit == (o_res.outcome == OC_HIT)))
        else $error("hit flag and outcome disagree");

    // early rejects carry a zero distance
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.outcome == OC_PARALLEL || o_res.outcome == OC_EMPTY)
        |-> (o_res.hit_distance == 32'sd0))
        else $error("early reject with nonzero distance");

    // a hit lies within the ray
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit
        |-> (o_res.hit_distance >= 0 && o_res.hit_distance <= $signed({1'b0, r_ray_len})))
        else $error("hit distance outside ray");

endmodule

[sim/ray_aabb_slab_intersect_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersect_top_tb
// self-checking bench for the fixed-point ray versus box slab test
// ----------------------------------------------------------------------------
// a table of directed boxes runs first, then special directed rays, then random
// rays and boxes; each accepted request is predicted in 64-bit arithmetic and
// queued, and each result is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersect_top_tb;
    import rai_pkg::*;

    localparam int N_RANDOM   = 2000;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYC  = 60;

    // index past the register list, writes to it are dropped
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct {
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
    } box_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hdist;
        logic [1:0]         code;
    } hit_t;

    // directed row: box plus optional typed-in answer
    typedef struct {
        box_t box;
        logic known;
        hit_t ans;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    rai_box_if box_ch ();
    rai_res_if res_ch ();

    ray_aabb_slab_intersect_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_box      (box_ch.sink),
        .o_res      (res_ch.source)
    );

    // local copy of the ray registers
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic [30:0]        ray_len;

    hit_t pending_hits [$];
    int   n_errors;
    int   n_accepted;
    int   n_results;
    int   n_code [4];
    int   idle_cycles;
    bit   sink_idle_on;
    bit   hold_off_req;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic signed [63:0] sat_q16(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact slab test, same bit behavior as the block
    function automatic hit_t slab_test(input box_t b);
        logic signed [63:0] t_near, t_far, t1, t2, tmp, d, ad, diff;
        hit_t r;
        t_near = -64'sd2147483648;
        t_far  = 64'sd2147483647;
        r = '0;
        for (int a = 0; a < 3; a++) begin
            d  = ray_dir[a];
            ad = (d < 0) ? -d : d;
            if (ad < 64'sd1074) begin
                if (ray_org[a] < b.lo[a] || ray_org[a] > b.hi[a]) begin
                    r.code = OC_PARALLEL;
                    return r;
                end
            end else begin
                diff = 64'(b.lo[a]) - 64'(ray_org[a]);
                t1 = sat_q16((diff <<< 30) / d);
                diff = 64'(b.hi[a]) - 64'(ray_org[a]);
                t2 = sat_q16((diff <<< 30) / d);
                if (t1 > t2) begin
                    tmp = t1; t1 = t2; t2 = tmp;
                end
                if (t1 > t_near) t_near = t1;
                if (t2 < t_far) t_far = t2;
                if (t_near > t_far) begin
                    r.code = OC_EMPTY;
                    return r;
                end
            end
        end
        tmp = (t_near >= 0) ? t_near : t_far;
        r.hdist = tmp[31:0];
        if (tmp >= 0 && tmp <= 64'(ray_len)) begin
            r.hit = 1'b1;
            r.code = OC_HIT;
        end else begin
            r.code = OC_RANGE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // write enable stays up; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_ORIGIN_X: ray_org[0] = val;
            REG_ORIGIN_Y: ray_org[1] = val;
            REG_ORIGIN_Z: ray_org[2] = val;
            REG_DIR_X:    ray_dir[0] = val;
            REG_DIR_Y:    ray_dir[1] = val;
            REG_DIR_Z:    ray_dir[2] = val;
            REG_RAY_LEN:  ray_len    = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                           input logic [31:0] len);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_RAY_LEN, len);
        i_cfg_we <= 1'b0;
    endtask

    // stop offering, wait for every result, then let the pipe settle
    task automatic wait_drained();
        box_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // offer one request, holding it until accepted; gap is the idle before it
    task automatic send_box(input box_t b, input int gap);
        if (gap > 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= b.lo[0];
        box_ch.box_min_y <= b.lo[1];
        box_ch.box_min_z <= b.lo[2];
        box_ch.box_max_x <= b.hi[0];
        box_ch.box_max_y <= b.hi[1];
        box_ch.box_max_z <= b.hi[2];
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        pending_hits.push_back(slab_test(b));
        n_accepted++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(0, 2000 << 16)) - (1000 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $signed($urandom_range(0, 2146)) - 1073;
            2: return $urandom_range(0, 1) ? 32'sd1073741824 : -32'sd1073741824;
            3: return $urandom_range(0, 1) ? 32'sd1074 : -32'sd1074;
            4: return $urandom();
            default: return $signed($urandom_range(0, 2147483647)) - 1073741824;
        endcase
    endfunction

    // mostly boxes near the ray so the slab path is exercised, some pure noise
    function automatic box_t rand_box();
        box_t b;
        logic signed [31:0] c, h;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 9) < 7) begin
                c = ray_org[a] + ($signed($urandom_range(0, 400 << 16)) - (200 << 16));
                h = $urandom_range(0, 50 << 16);
                b.lo[a] = c - h;
                b.hi[a] = c + h;
                if ($urandom_range(0, 15) == 0) begin
                    c = b.lo[a]; b.lo[a] = b.hi[a]; b.hi[a] = c;
                end
            end else begin
                b.lo[a] = rand_coord();
                b.hi[a] = rand_coord();
            end
        end
        return b;
    endfunction

    // result side: random ready bursts, plus one long hold-off on request
    initial begin
        int burst;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 16);
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        hit_t want;
        if (i_rst_n) begin
            if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (pending_hits.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = pending_hits.pop_front();
                    n_code[want.code]++;
                    if (res_ch.hit !== want.hit)
                        report_mismatch($sformatf("hit %b want %b", res_ch.hit, want.hit));
                    if (res_ch.hit_distance !== want.hdist)
                        report_mismatch($sformatf("hit_distance %h want %h",
                                                  res_ch.hit_distance, want.hdist));
                    if (res_ch.outcome !== want.code)
                        report_mismatch($sformatf("outcome %0d want %0d",
                                                  res_ch.outcome, want.code));
                end
            end
        end
    end

    // directed table and random phases
    initial begin
        row_t rows [$];
        row_t rw;
        box_t b;
        int gap;
        n_errors = 0; n_accepted = 0; n_results = 0; idle_cycles = 0;
        n_code = '{0, 0, 0, 0};
        sink_idle_on = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        box_ch.valid = 1'b0;
        box_ch.box_min_x = '0; box_ch.box_min_y = '0; box_ch.box_min_z = '0;
        box_ch.box_max_x = '0; box_ch.box_max_y = '0; box_ch.box_max_z = '0;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 32'sd1073741824};
        ray_len = 31'd65536000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default ray: +z from the origin, length 1000
        // box z 5..10 hit at 5.0
        rw.box = '{lo: '{-65536, -65536, 5 << 16}, hi: '{65536, 65536, 10 << 16}};
        rw.known = 1; rw.ans = '{1'b1, 32'sd327680, OC_HIT}; rows.push_back(rw);
        // x slab misses the parallel axis
        rw.box = '{lo: '{65536, -65536, 0}, hi: '{131072, 65536, 65536}};
        rw.known = 1; rw.ans = '{1'b0, 32'sd0, OC_PARALLEL}; rows.push_back(rw);
        // inverted box on a parallel axis
        rw.box = '{lo: '{65536, -65536, 0}, hi: '{-65536, 65536, 65536}};
        rw.known = 1; rw.ans = '{1'b0, 32'sd0, OC_PARALLEL}; rows.push_back(rw);
        // inverted box on the z axis still ordered
        rw.box = '{lo: '{-65536, -65536, 10 << 16}, hi: '{65536, 65536, 5 << 16}};
        rw.known = 1; rw.ans = '{1'b1, 32'sd327680, OC_HIT}; rows.push_back(rw);
        // box behind origin, far end negative
        rw.box = '{lo: '{-65536, -65536, -(10 << 16)}, hi: '{65536, 65536, -(5 << 16)}};
        rw.known = 1; rw.ans = '{1'b0, -32'sd327680, OC_RANGE}; rows.push_back(rw);
        // origin inside, exit distance chosen
        rw.box = '{lo: '{-65536, -65536, -65536}, hi: '{65536, 65536, 3 << 16}};
        rw.known = 1; rw.ans = '{1'b1, 32'sd196608, OC_HIT}; rows.push_back(rw);
        // beyond ray length
        rw.box = '{lo: '{-65536, -65536, 2000 << 16}, hi: '{65536, 65536, 2001 << 16}};
        rw.known = 1; rw.ans = '{1'b0, 32'sd131072000, OC_RANGE}; rows.push_back(rw);
        // field extremes, saturated distances
        rw.box = '{lo: '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                   hi: '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}};
        rw.known = 0; rows.push_back(rw);
        rw.box = '{lo: '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                   hi: '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}};
        rw.known = 0; rows.push_back(rw);
        rw.box = '{lo: '{0, 0, 32'sh7fff_ffff}, hi: '{0, 0, 32'sh7fff_ffff}};
        rw.known = 0; rows.push_back(rw);
        foreach (rows[i]) begin
            send_box(rows[i].box, 0);
            if (rows[i].known && slab_test(rows[i].box) != rows[i].ans)
                report_mismatch($sformatf("directed row %0d prediction off", i));
        end
        wait_drained();

        // all axes parallel, origin inside: distance saturates at the top
        set_ray(0, 0, 0, 0, 1073, -1073, 32'h7fff_ffff);
        b = '{lo: '{-65536, -65536, -65536}, hi: '{65536, 65536, 65536}};
        send_box(b, 0);
        if (slab_test(b) != hit_t'{1'b1, 32'sh7fff_ffff, OC_HIT})
            report_mismatch("all-parallel hit prediction off");
        wait_drained();
        write_reg(REG_NONE, 32'hdead_beef);   // unused index, ignored
        write_reg(REG_RAY_LEN, 32'hffff_fffe);
        i_cfg_we <= 1'b0;
        send_box(b, 0);
        // diagonal ray with extreme origin, empty interval and saturation cases
        wait_drained();
        set_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'sd1074, -32'sd1074, 32'h8000_0000, 0);
        for (int i = 0; i < 8; i++) begin
            b.lo = '{rand_coord(), rand_coord(), rand_coord()};
            b.hi = '{rand_coord(), rand_coord(), rand_coord()};
            send_box(b, 0);
        end
        wait_drained();

        // random phases: new ray each phase, idling in early phases only
        for (int ph = 0; ph < 20; ph++) begin
            set_ray(($urandom_range(0, 3) == 0) ? rand_coord()
                        : $signed($urandom_range(0, 200 << 16)) - (100 << 16),
                    ($urandom_range(0, 3) == 0) ? rand_coord()
                        : $signed($urandom_range(0, 200 << 16)) - (100 << 16),
                    ($urandom_range(0, 3) == 0) ? rand_coord()
                        : $signed($urandom_range(0, 200 << 16)) - (100 << 16),
                    rand_dir(), rand_dir(), rand_dir(),
                    ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 500 << 16));
            sink_idle_on = (ph < 16) && (ph % 4 != 3);
            if (ph == 2) hold_off_req = 1'b1;   // long receiver stall fills the pipe
            for (int i = 0; i < N_RANDOM / 20; i++) begin
                gap = 0;
                if (ph < 16 && ph % 4 != 1 && $urandom_range(0, 4) == 0)
                    gap = $urandom_range(1, 16);
                send_box(rand_box(), gap);
            end
            wait_drained();   // sender pauses until every result is back
        end

        $display("%0d requests, %0d results: hit %0d parallel %0d empty %0d range %0d",
                 n_accepted, n_results, n_code[0], n_code[1], n_code[2], n_code[3]);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rai_pkg.sv
hw/rtl/rai_ifs.sv
hw/rtl/rai_front.sv
hw/rtl/rai_cell.sv
hw/rtl/rai_back.sv
hw/rtl/ray_aabb_slab_intersect_top.sv
sim/ray_aabb_slab_intersect_top_tb.sv
